### rtl/siphash_keyed_hash_unit_macros.svh
// Assertion macros shared by the SipHash keyed hash unit.
`ifndef SIPHASH_KEYED_HASH_UNIT_MACROS_SVH
`define SIPHASH_KEYED_HASH_UNIT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define SIPHASH_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define SIPHASH_ASSERT_NEXT(label, trig, cons, msg) \
   `SIPHASH_ASSERT(label, (trig) |=> (cons), msg)

`endif

### rtl/siphash_pkg.sv
// Package with the types, constants and helpers of the SipHash keyed hash unit.
`default_nettype none

package siphash_pkg;

   localparam int COMPRESS_ROUNDS = 2;
   localparam int FINAL_ROUNDS = 4;
   localparam int MAX_ROUNDS = (FINAL_ROUNDS > COMPRESS_ROUNDS) ? FINAL_ROUNDS : COMPRESS_ROUNDS;
   localparam int ROUND_COUNT_WIDTH = $clog2(MAX_ROUNDS + 1);

   localparam int WORD_WIDTH = 64;
   localparam int COUNT_WIDTH = 4;
   localparam int LENGTH_WIDTH = 8;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int LENGTH_SHIFT = 56;

   localparam logic [WORD_WIDTH-1:0] SEED_A = 64'h736f6d6570736575;
   localparam logic [WORD_WIDTH-1:0] SEED_B = 64'h646f72616e646f6d;
   localparam logic [WORD_WIDTH-1:0] SEED_C = 64'h6c7967656e657261;
   localparam logic [WORD_WIDTH-1:0] SEED_D = 64'h7465646279746573;
   localparam logic [WORD_WIDTH-1:0] FINISH_MARK = 64'hff;
   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = 4'd8;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_KEY_LOW  = 1'b0,
      CSR_KEY_HIGH = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPRESS,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] a;
      logic [WORD_WIDTH-1:0] b;
      logic [WORD_WIDTH-1:0] c;
      logic [WORD_WIDTH-1:0] d;
   } lanes_type;

   // Keeps the low bytes of a word; count is below eight here.
   function automatic logic [WORD_WIDTH-1:0] tail_mask(input logic [2:0] count);
      logic [WORD_WIDTH-1:0] mask;
      mask = '0;
      for (int i = 0; i < 8; i++) begin
         if (3'(i) < count) begin
            mask[8*i +: 8] = 8'hff;
         end
      end
      return mask;
   endfunction

endpackage

`default_nettype wire

### rtl/siphash_if.sv
// Handshake interfaces for the message word and hash result channels.
`default_nettype none

interface siphash_req_if;
   import siphash_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [WORD_WIDTH-1:0]  word_data;
   logic [COUNT_WIDTH-1:0] byte_count;
   logic                   last_word;

   modport source (output valid, output word_data, output byte_count, output last_word,
                   input ready);
   modport sink (input valid, input word_data, input byte_count, input last_word,
                 output ready);
endinterface

interface siphash_rsp_if;
   import siphash_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [WORD_WIDTH-1:0] hash_value;

   modport source (output valid, output hash_value, input ready);
   modport sink (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

### rtl/siphash_round.sv
// One SipRound over the four lanes of the hash state.
`default_nettype none

module siphash_round (
   input  siphash_pkg::lanes_type lanes_in,
   output siphash_pkg::lanes_type lanes_out
);
   import siphash_pkg::*;

   function automatic logic [WORD_WIDTH-1:0] rot_left(input logic [WORD_WIDTH-1:0] x,
                                                      input int n);
      return (x << n) | (x >> (WORD_WIDTH - n));
   endfunction

   logic [WORD_WIDTH-1:0] a1, b1, c1, d1;
   logic [WORD_WIDTH-1:0] a2, b2, c2, d2;

   always_comb begin
      a1 = lanes_in.a + lanes_in.b;
      b1 = rot_left(lanes_in.b, 13) ^ a1;
      c1 = lanes_in.c + lanes_in.d;
      d1 = rot_left(lanes_in.d, 16) ^ c1;
      a2 = rot_left(a1, 32) + d1;
      d2 = rot_left(d1, 21) ^ a2;
      c2 = c1 + b1;
      b2 = rot_left(b1, 17) ^ c2;
      lanes_out.a = a2;
      lanes_out.b = b2;
      lanes_out.c = rot_left(c2, 32);
      lanes_out.d = d2;
   end

endmodule

`default_nettype wire

### rtl/siphash_keyed_hash_unit.sv
// Top level of the SipHash-2-4 keyed hash unit.
// The unit hashes a message that arrives as little-endian 64-bit words and returns one
// 64-bit hash item after the last word. A single round unit performs one SipRound per
// clock, unless the last finalization round waits for the output register to free up.
// A word that is not the last is taken while idle and compressed before the next word
// is taken; a last word of all eight bytes adds a compression of the length word, and
// the state is then finalized. The hash waits in an output register while the next
// message starts. The key is sampled only when the first word of a message is taken.
`default_nettype none

module siphash_keyed_hash_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   siphash_req_if.sink                              req_channel,
   siphash_rsp_if.source                            rsp_channel,
   input  wire logic                                csr_write_enable,
   input  wire logic [siphash_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [siphash_pkg::WORD_WIDTH-1:0]  csr_write_data
);
   import siphash_pkg::*;

`include "siphash_keyed_hash_unit_macros.svh"

   state_type                     state_ff, state_in;
   lanes_type                     lanes_ff, lanes_in;
   lanes_type                     round_out;
   logic [WORD_WIDTH-1:0]         key_low_ff, key_high_ff;
   logic [WORD_WIDTH-1:0]         word_ff, word_in;
   logic [WORD_WIDTH-1:0]         next_ff, next_in;
   logic                          pending_ff, pending_in;
   logic                          last_ff, last_in;
   logic                          in_message_ff, in_message_in;
   logic [LENGTH_WIDTH-1:0]       length_ff, length_in;
   logic [ROUND_COUNT_WIDTH-1:0]  count_ff, count_in;
   logic [WORD_WIDTH-1:0]         hash_ff, hash_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   lanes_type                     seed_lanes, base_lanes, after;
   logic [LENGTH_WIDTH-1:0]       base_length, length_new;
   logic                          full_last, accept;
   logic [WORD_WIDTH-1:0]         tail_word, first_word;

   siphash_round u_round (
      .lanes_in  (lanes_ff),
      .lanes_out (round_out)
   );

   assign req_channel.ready      = (state_ff == ST_IDLE);
   assign rsp_channel.valid      = rsp_valid_ff;
   assign rsp_channel.hash_value = hash_ff;
   assign accept                 = req_channel.valid && req_channel.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_KEY_LOW:  key_low_ff <= csr_write_data;
            CSR_KEY_HIGH: key_high_ff <= csr_write_data;
            default:      key_low_ff <= key_low_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         lanes_ff      <= '0;
         pending_ff    <= 1'b0;
         last_ff       <= 1'b0;
         in_message_ff <= 1'b0;
         length_ff     <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lanes_ff      <= lanes_in;
         pending_ff    <= pending_in;
         last_ff       <= last_in;
         in_message_ff <= in_message_in;
         length_ff     <= length_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      word_ff <= word_in;
      next_ff <= next_in;
      hash_ff <= hash_in;
   end

   always_comb begin
      seed_lanes.a = SEED_A ^ key_low_ff;
      seed_lanes.b = SEED_B ^ key_high_ff;
      seed_lanes.c = SEED_C ^ key_low_ff;
      seed_lanes.d = SEED_D ^ key_high_ff;
      base_lanes   = in_message_ff ? lanes_ff : seed_lanes;
      base_length  = in_message_ff ? length_ff : '0;

      full_last = req_channel.last_word && (req_channel.byte_count >= FULL_COUNT);
      if (req_channel.last_word && !full_last) begin
         length_new = base_length + LENGTH_WIDTH'(req_channel.byte_count);
         tail_word  = (WORD_WIDTH'(length_new) << LENGTH_SHIFT)
                    | (req_channel.word_data & tail_mask(req_channel.byte_count[2:0]));
         first_word = tail_word;
      end else begin
         length_new = base_length + LENGTH_WIDTH'(FULL_COUNT);
         tail_word  = WORD_WIDTH'(length_new) << LENGTH_SHIFT;
         first_word = req_channel.word_data;
      end

      state_in      = state_ff;
      lanes_in      = lanes_ff;
      word_in       = word_ff;
      next_in       = next_ff;
      pending_in    = pending_ff;
      last_in       = last_ff;
      in_message_in = in_message_ff;
      length_in     = length_ff;
      count_in      = count_ff;
      hash_in       = hash_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_channel.ready;
      after         = round_out;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               lanes_in      = base_lanes;
               lanes_in.d    = base_lanes.d ^ first_word;
               word_in       = first_word;
               next_in       = tail_word;
               pending_in    = full_last;
               last_in       = req_channel.last_word;
               in_message_in = !req_channel.last_word;
               length_in     = length_new;
               count_in      = '0;
               state_in      = ST_COMPRESS;
            end
         end
         ST_COMPRESS: begin
            count_in = count_ff + ROUND_COUNT_WIDTH'(1);
            if (count_ff == ROUND_COUNT_WIDTH'(COMPRESS_ROUNDS - 1)) begin
               after.a  = round_out.a ^ word_ff;
               count_in = '0;
               if (pending_ff) begin
                  after.d    = round_out.d ^ next_ff;
                  word_in    = next_ff;
                  pending_in = 1'b0;
               end else if (last_ff) begin
                  after.c  = round_out.c ^ FINISH_MARK;
                  state_in = ST_FINAL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
            lanes_in = after;
         end
         ST_FINAL: begin
            if (count_ff == ROUND_COUNT_WIDTH'(FINAL_ROUNDS - 1)) begin
               if (!rsp_valid_ff || rsp_channel.ready) begin
                  lanes_in     = round_out;
                  hash_in      = round_out.a ^ round_out.b ^ round_out.c ^ round_out.d;
                  rsp_valid_in = 1'b1;
                  last_in      = 1'b0;
                  count_in     = '0;
                  state_in     = ST_IDLE;
               end
            end else begin
               lanes_in = round_out;
               count_in = count_ff + ROUND_COUNT_WIDTH'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `SIPHASH_ASSERT(a_result_from_final, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINAL,
                   "hash item appeared without finalization")
   `SIPHASH_ASSERT_NEXT(a_last_closes_message, accept && req_channel.last_word,
                        !in_message_ff, "message still open after its last word")
   `SIPHASH_ASSERT(a_compress_count_bound,
                   state_ff == ST_COMPRESS |-> count_ff < ROUND_COUNT_WIDTH'(COMPRESS_ROUNDS),
                   "compression round count overran")
   `SIPHASH_ASSERT(a_pending_only_on_last, pending_ff |-> last_ff,
                   "length word pending on a word that is not the last")

endmodule

`default_nettype wire
